[rtl/ots_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the ordered topological sort unit.
// Depends on nothing; every other file imports it.
package ots_pkg;

   // Width of a node index as carried on the ports.
   localparam int unsigned NODE_FIELD_W = 6;
   // Largest node count that the node index field can address.
   localparam int unsigned NODE_LIMIT   = 2 ** NODE_FIELD_W;
   // Width of the node count register.
   localparam int unsigned COUNT_REG_W  = 7;
   // Reset value of the node count register.
   localparam logic [COUNT_REG_W-1:0] NODE_COUNT_RESET = 7'd64;

   typedef enum logic [0:0] {
      CMD_ADD_EDGE = 1'b0,
      CMD_START    = 1'b1
   } command_type;

   typedef struct packed {
      command_type             command;
      logic [NODE_FIELD_W-1:0] edge_from;
      logic [NODE_FIELD_W-1:0] edge_to;
   } req_payload_type;

   typedef struct packed {
      logic [NODE_FIELD_W-1:0] node_index;
      logic                    has_node;
      logic                    is_last;
      logic                    incomplete;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_SELECT,
      ST_SCAN,
      ST_DRAIN
   } sort_state_type;

endpackage

[rtl/ordered_topological_sort_unit.sv]
`timescale 1ns / 1ps
// Ordered topological sort unit (Kahn's method, lowest index first); depends on ots_pkg.
// An add-edge transaction is taken every cycle while the unit is idle and gives no result.
// A start runs the sort with the request channel stalled: per emitted node, a pick through
// the pick tree, a scan of every stored edge and a drain, plus any output stall.
// The final result is registered once no node is left to pick; the stores clear with it.
// Reset is synchronous and active high: it empties the graph and sets node_count to 64.
module ordered_topological_sort_unit
   import ots_pkg::*;
#(
   parameter int unsigned MAX_NODES = 64,
   parameter int unsigned MAX_EDGES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_write_enable,
   input  logic [COUNT_REG_W-1:0] csr_write_data
);

   // Node slots actually addressable: the parameter, capped by the index field.
   localparam int unsigned NODE_SLOTS = (MAX_NODES < NODE_LIMIT) ? MAX_NODES : NODE_LIMIT;
   localparam int unsigned NODE_AW    = $clog2(NODE_SLOTS);
   localparam int unsigned CNT_W      = $clog2(NODE_SLOTS + 1);
   localparam int unsigned EDGE_AW    = $clog2(MAX_EDGES);
   localparam int unsigned HELD_W     = $clog2(MAX_EDGES + 1);
   localparam int unsigned DEG_W      = $clog2(MAX_EDGES + 1);
   // The pick tree works on groups of eight candidates.
   localparam int unsigned GROUPS     = (NODE_SLOTS + 7) / 8;

   // ------------------------------------------------------------------
   // Control state
   // ------------------------------------------------------------------
   sort_state_type state_ff, state_in;

   logic [COUNT_REG_W-1:0] node_count_ff;
   logic [HELD_W-1:0]      edges_held_ff;
   logic [EDGE_AW-1:0]     scan_idx_ff;
   logic [CNT_W-1:0]       emitted_ff;
   logic                   pend_valid_ff;
   logic [NODE_AW-1:0]     pend_node_ff;

   // Per-node flags kept in flip-flops: the in-degree memory entry has been written
   // since the last clear, the in-degree is nonzero, and the node has been emitted.
   logic [NODE_SLOTS-1:0]  deg_valid_ff;
   logic [NODE_SLOTS-1:0]  nonzero_ff;
   logic [NODE_SLOTS-1:0]  visited_ff;

   // ------------------------------------------------------------------
   // Memories: the edge list and the in-degree counters.
   // ------------------------------------------------------------------
   logic [2*NODE_AW-1:0] edge_mem [MAX_EDGES];
   logic [DEG_W-1:0]     deg_mem  [NODE_SLOTS];

   logic [2*NODE_AW-1:0] edge_rd_ff;
   logic [DEG_W-1:0]     deg_rd_ff;

   // Edge scan stage: edge memory data is valid in the cycle after the read.
   logic e1_valid_ff;
   // In-degree update stage: read data is valid, the new count is written back.
   logic               s2_valid_ff;
   logic               s2_inc_ff;
   logic [NODE_AW-1:0] s2_addr_ff;
   // The write of the previous cycle, forwarded when the same counter comes back.
   logic               last_wr_en_ff;
   logic [NODE_AW-1:0] last_wr_addr_ff;
   logic [DEG_W-1:0]   last_wr_data_ff;

   // Registered first level of the pick tree.
   logic             grp_any_ff   [GROUPS];
   logic [2:0]       grp_first_ff [GROUPS];

   // Output register.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   // ------------------------------------------------------------------
   // Combinational signals
   // ------------------------------------------------------------------
   logic               req_accept;
   logic               add_ok;
   logic [NODE_AW-1:0] req_from;
   logic [NODE_AW-1:0] req_to;
   logic [CNT_W-1:0]   active_n;
   logic [NODE_SLOTS-1:0] candidate;
   logic               grp_any_in   [GROUPS];
   logic [2:0]         grp_first_in [GROUPS];
   logic               sel_found;
   logic [NODE_AW-1:0] sel_node;
   logic               out_free;
   logic               scan_last;
   logic               e1_match;
   logic [NODE_AW-1:0] deg_rd_addr;
   logic [DEG_W-1:0]   deg_old;
   logic [DEG_W-1:0]   deg_new;

   // Sequencer outputs.
   logic take_node;
   logic emit;
   logic emit_last;
   logic do_clear;
   logic scan_issue;

   // ------------------------------------------------------------------
   // Input side. Transactions are taken only while the sequencer is idle;
   // edge additions stream at one per cycle through the update pipeline.
   // ------------------------------------------------------------------
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_from   = NODE_AW'(req_payload.edge_from);
   assign req_to     = NODE_AW'(req_payload.edge_to);

   // An edge is stored only while the list has room and both ends name a node slot.
   assign add_ok = req_accept && (req_payload.command == CMD_ADD_EDGE)
                   && (edges_held_ff < HELD_W'(MAX_EDGES))
                   && (32'(req_payload.edge_from) < MAX_NODES)
                   && (32'(req_payload.edge_to) < MAX_NODES);

   // Node count in use, limited to the slots that exist.
   assign active_n = (node_count_ff > COUNT_REG_W'(NODE_SLOTS)) ? CNT_W'(NODE_SLOTS)
                                                               : CNT_W'(node_count_ff);

   // ------------------------------------------------------------------
   // Pick tree. A node qualifies when it is inside the active count, has not
   // been emitted and has in-degree zero. The first level finds the lowest
   // qualifying node in each group of eight; the second picks the lowest group.
   // ------------------------------------------------------------------
   always_comb begin
      for (int i = 0; i < NODE_SLOTS; i++) begin
         candidate[i] = !visited_ff[i] && !nonzero_ff[i] && (CNT_W'(i) < active_n);
      end
   end

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_any_in[g]   = 1'b0;
         grp_first_in[g] = 3'd0;
         for (int b = 7; b >= 0; b--) begin
            if ((g * 8 + b) < NODE_SLOTS) begin
               if (candidate[g * 8 + b]) begin
                  grp_any_in[g]   = 1'b1;
                  grp_first_in[g] = 3'(b);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FIND) begin
         for (int g = 0; g < GROUPS; g++) begin
            grp_any_ff[g]   <= grp_any_in[g];
            grp_first_ff[g] <= grp_first_in[g];
         end
      end
   end

   always_comb begin
      sel_found = 1'b0;
      sel_node  = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            sel_found = 1'b1;
            sel_node  = NODE_AW'(g * 8 + int'(grp_first_ff[g]));
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequencer: next state.
   // ------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_last = ((HELD_W'(scan_idx_ff) + HELD_W'(1)) == edges_held_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_payload.command == CMD_START)) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            state_in = ST_SELECT;
         end
         ST_SELECT: begin
            if (take_node) begin
               state_in = (edges_held_ff == '0) ? ST_DRAIN : ST_SCAN;
            end else if (do_clear) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!e1_valid_ff && !s2_valid_ff) begin
               state_in = ST_FIND;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer: outputs. A picked node is held back until the next pick is
   // known, so that its result can carry the end-of-run flag.
   // ------------------------------------------------------------------
   always_comb begin
      take_node  = 1'b0;
      emit       = 1'b0;
      emit_last  = 1'b0;
      do_clear   = 1'b0;
      scan_issue = 1'b0;
      unique case (state_ff)
         ST_SELECT: begin
            if (sel_found) begin
               if (!pend_valid_ff || out_free) begin
                  take_node = 1'b1;
                  emit      = pend_valid_ff;
               end
            end else if (out_free) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               do_clear  = 1'b1;
            end
         end
         ST_SCAN: begin
            scan_issue = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------
   // Configuration register.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_write_enable) begin
         node_count_ff <= csr_write_data;
      end
   end

   // ------------------------------------------------------------------
   // Edge list: written while loading, read in order while scanning.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (add_ok) begin
         edge_mem[edges_held_ff[EDGE_AW-1:0]] <= {req_from, req_to};
      end
      if (scan_issue) begin
         edge_rd_ff <= edge_mem[scan_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edges_held_ff <= '0;
         scan_idx_ff   <= '0;
         e1_valid_ff   <= 1'b0;
      end else begin
         if (do_clear) begin
            edges_held_ff <= '0;
         end else if (add_ok) begin
            edges_held_ff <= edges_held_ff + HELD_W'(1);
         end
         if (take_node) begin
            scan_idx_ff <= '0;
         end else if (scan_issue) begin
            scan_idx_ff <= scan_idx_ff + EDGE_AW'(1);
         end
         e1_valid_ff <= scan_issue;
      end
   end

   // An edge leaving the node just picked lowers its target's in-degree.
   assign e1_match = e1_valid_ff
                     && (edge_rd_ff[2*NODE_AW-1:NODE_AW] == pend_node_ff);

   // ------------------------------------------------------------------
   // In-degree read-modify-write. The read is registered ahead of the update; when the
   // counter read is the one written in that same cycle, the written value is
   // forwarded. A counter never written since the last clear reads as zero.
   // ------------------------------------------------------------------
   assign deg_rd_addr = add_ok ? req_to : edge_rd_ff[NODE_AW-1:0];

   always_ff @(posedge clock) begin
      deg_rd_ff <= deg_mem[deg_rd_addr];
      if (s2_valid_ff) begin
         deg_mem[s2_addr_ff] <= deg_new;
      end
   end

   always_comb begin
      if (!deg_valid_ff[s2_addr_ff]) begin
         deg_old = '0;
      end else if (last_wr_en_ff && (last_wr_addr_ff == s2_addr_ff)) begin
         deg_old = last_wr_data_ff;
      end else begin
         deg_old = deg_rd_ff;
      end
      if (s2_inc_ff) begin
         deg_new = deg_old + DEG_W'(1);
      end else if (deg_old == '0) begin
         deg_new = '0;
      end else begin
         deg_new = deg_old - DEG_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff   <= 1'b0;
         last_wr_en_ff <= 1'b0;
      end else begin
         s2_valid_ff   <= add_ok || e1_match;
         last_wr_en_ff <= s2_valid_ff;
      end
      s2_inc_ff       <= add_ok;
      s2_addr_ff      <= deg_rd_addr;
      last_wr_addr_ff <= s2_addr_ff;
      last_wr_data_ff <= deg_new;
   end

   // Per-node flags, cleared together on reset and at the end of a run.
   always_ff @(posedge clock) begin
      if (reset || do_clear) begin
         deg_valid_ff <= '0;
         nonzero_ff   <= '0;
         visited_ff   <= '0;
      end else begin
         if (s2_valid_ff) begin
            deg_valid_ff[s2_addr_ff] <= 1'b1;
            nonzero_ff[s2_addr_ff]   <= (deg_new != '0);
         end
         if (take_node) begin
            visited_ff[sel_node] <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Pending node and emitted count.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset || do_clear) begin
         pend_valid_ff <= 1'b0;
         emitted_ff    <= '0;
      end else if (take_node) begin
         pend_valid_ff <= 1'b1;
         emitted_ff    <= emitted_ff + CNT_W'(1);
      end
      if (take_node) begin
         pend_node_ff <= sel_node;
      end
   end

   // ------------------------------------------------------------------
   // Output register. The final transaction of a run carries the held node if
   // there is one, else no node; it is incomplete when fewer nodes came out
   // than the active count.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) begin
         rsp_payload_ff.node_index <= pend_valid_ff ? NODE_FIELD_W'(pend_node_ff) : '0;
         rsp_payload_ff.has_node   <= pend_valid_ff;
         rsp_payload_ff.is_last    <= emit_last;
         rsp_payload_ff.incomplete <= emit_last && (emitted_ff < active_n);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for ordered_topological_sort_unit: loads edge lists, starts sorts and checks
// every emitted node against a lowest-index-first Kahn predictor held in a scoreboard.
// Depends on ots_pkg and the unit's RTL.
import ots_pkg::*;

// Tracks the graph the unit should be holding and the emit order it owes.
class sort_scoreboard;
   localparam int unsigned EDGE_SLOTS = 256;

   logic [COUNT_REG_W-1:0]  node_count;
   logic [NODE_FIELD_W-1:0] edge_src [EDGE_SLOTS];
   logic [NODE_FIELD_W-1:0] edge_dst [EDGE_SLOTS];
   int unsigned             edges_held;
   int unsigned             in_deg [NODE_LIMIT];
   bit                      visited [NODE_LIMIT];
   rsp_payload_type         pending [$];
   int unsigned             mismatches;
   int unsigned             results_seen;
   int unsigned             sorts_run;

   function new();
      node_count   = NODE_COUNT_RESET;
      mismatches   = 0;
      results_seen = 0;
      sorts_run    = 0;
      clear_graph();
   endfunction

   function void clear_graph();
      edges_held = 0;
      foreach (in_deg[i]) begin
         in_deg[i]  = 0;
         visited[i] = 1'b0;
      end
   endfunction

   function int unsigned lowest_ready(input int unsigned span);
      for (int unsigned i = 0; i < span; i++) begin
         if (!visited[i] && in_deg[i] == 0) return i;
      end
      return span;
   endfunction

   // Called once per accepted request transaction.
   function void note_request(input req_payload_type item);
      rsp_payload_type order [$];
      rsp_payload_type word;
      int unsigned     span;
      int unsigned     node;
      if (item.command == CMD_ADD_EDGE) begin
         // A full edge store drops the edge without touching the in-degrees.
         if (edges_held < EDGE_SLOTS) begin
            edge_src[edges_held] = item.edge_from;
            edge_dst[edges_held] = item.edge_to;
            edges_held++;
            in_deg[item.edge_to]++;
         end
         return;
      end
      sorts_run++;
      span = (node_count > NODE_LIMIT) ? NODE_LIMIT : node_count;
      node = lowest_ready(span);
      while (node < span) begin
         visited[node] = 1'b1;
         for (int unsigned e = 0; e < edges_held; e++) begin
            if (edge_src[e] == node && in_deg[edge_dst[e]] != 0) in_deg[edge_dst[e]]--;
         end
         word            = '0;
         word.node_index = node[NODE_FIELD_W-1:0];
         word.has_node   = 1'b1;
         order           = {order, word};
         node = lowest_ready(span);
      end
      if (order.size() == 0) begin
         // Nothing was ready: a single empty result, flagged unless the graph is empty.
         word            = '0;
         word.is_last    = 1'b1;
         word.incomplete = (span != 0);
         order           = {order, word};
      end else begin
         word            = order.pop_back();
         word.is_last    = 1'b1;
         word.incomplete = (order.size() + 1 < span);
         order           = {order, word};
      end
      pending = {pending, order};
      clear_graph();
   endfunction

   // Called once per accepted result transaction.
   function void check_result(input rsp_payload_type got);
      rsp_payload_type want;
      results_seen++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Unexpected result: node %0d has_node %0b last %0b incomplete %0b",
                     got.node_index, got.has_node, got.is_last, got.incomplete);
         return;
      end
      want = pending.pop_front();
      if (got.node_index !== want.node_index || got.has_node !== want.has_node ||
          got.is_last !== want.is_last || got.incomplete !== want.incomplete) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"Mismatch on result %0d: expected node %0d has_node %0b last %0b ",
                      "incomplete %0b, got node %0d has_node %0b last %0b incomplete %0b"},
                     results_seen, want.node_index, want.has_node, want.is_last,
                     want.incomplete, got.node_index, got.has_node, got.is_last,
                     got.incomplete);
      end
   endfunction
endclass

module tb_top;
   localparam int          HALF_PERIOD   = 10;
   localparam int          RESET_CYCLES  = 8;
   // Cycles allowed after the last result before the unit counts as idle; covers the
   // store clear that follows a sort and any edge write still in flight.
   localparam int          SETTLE_CYCLES = 16;
   // Long receiver hold-off that backs the unit up into its request channel.
   localparam int          HOLD_CYCLES   = 400;
   // The slowest legal gap between transactions is one node's scan of a full edge store
   // stretched by receiver stalls, or the hold-off above.
   localparam int unsigned WATCHDOG_LIMIT = 20000;
   localparam int unsigned PHASE_ITEMS    = 18;

   // Edge-list shapes for generated graphs.
   localparam int SHAPE_DAG  = 0;  // edges follow a random order, so every node sorts
   localparam int SHAPE_ANY  = 1;  // free edges inside the graph, cycles likely
   localparam int SHAPE_WIDE = 2;  // endpoints anywhere in the index range
   localparam int SHAPE_DUP  = 3;  // ordered edges with frequent repeats

   logic            clock            = 1'b0;
   logic            reset            = 1'b1;
   logic            req_valid        = 1'b0;
   logic            req_stall;
   req_payload_type req_payload      = '0;
   logic            rsp_valid;
   logic            rsp_stall        = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable = 1'b0;
   logic [COUNT_REG_W-1:0] csr_write_data = '0;

   int unsigned sender_pct     = 0;
   int unsigned receiver_pct   = 0;
   int unsigned hold_asks      = 0;
   int unsigned hold_served    = 0;
   int unsigned hold_left      = 0;
   int unsigned idle_cycles    = 0;
   int unsigned items_offered  = 0;
   int unsigned settings_used  = 0;

   sort_scoreboard sb;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   ordered_topological_sort_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Monitor. Values are read right after the edge, before any update scheduled by it,
   // so each transaction is seen exactly as it was accepted. Requests are noted before
   // results so that a start always has its expectations queued first.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
      end
   end

   // Watchdog: any transaction, on either channel or the register port, restarts it.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles, %0d results still expected",
                  WATCHDOG_LIMIT, sb.pending.size());
         $display("tb_top failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver. A hold request from the stimulus turns into a long unbroken stall that
   // this process counts itself; otherwise it stalls at random at the current rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asks) begin
         hold_served <= hold_asks;
         hold_left   <= HOLD_CYCLES - 1;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= (receiver_pct != 0) && ($urandom_range(99) < receiver_pct);
      end
   end

   // Offers one request transaction and returns at the edge that accepts it. Valid is
   // left high so a following item goes out back to back; a gap lowers it first.
   task automatic send_item(input command_type cmd, input int unsigned from_node,
                            input int unsigned to_node);
      req_payload_type item;
      item.command   = cmd;
      item.edge_from = from_node[NODE_FIELD_W-1:0];
      item.edge_to   = to_node[NODE_FIELD_W-1:0];
      if (sender_pct != 0 && $urandom_range(99) < sender_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      items_offered++;
   endtask

   // Stops offering and waits until every owed result has come out, then lets the
   // unit finish its cleanup.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_node_count(input int unsigned value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value[COUNT_REG_W-1:0];
      @(posedge clock);
      sb.node_count = value[COUNT_REG_W-1:0];
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // Sends edge_total edges of the given shape, below span unless wide, then a start.
   task automatic send_graph(input int unsigned span, input int unsigned edge_total,
                             input int shape);
      int unsigned order [NODE_LIMIT];
      int unsigned pick;
      int unsigned swap;
      int unsigned a;
      int unsigned b;
      for (int unsigned i = 0; i < NODE_LIMIT; i++) order[i] = i;
      for (int unsigned i = span - 1; i > 0; i--) begin
         pick        = $urandom_range(i);
         swap        = order[i];
         order[i]    = order[pick];
         order[pick] = swap;
      end
      a = 0;
      b = 0;
      for (int unsigned e = 0; e < edge_total; e++) begin
         if (shape == SHAPE_WIDE) begin
            a = $urandom_range(NODE_LIMIT - 1);
            b = $urandom_range(NODE_LIMIT - 1);
         end else if (shape == SHAPE_ANY || span < 2) begin
            a = order[$urandom_range(span - 1)];
            b = order[$urandom_range(span - 1)];
         end else if (shape != SHAPE_DUP || e == 0 || $urandom_range(1) == 0) begin
            // An edge from an earlier to a later position of the shuffled order.
            pick = $urandom_range(span - 2);
            a    = order[pick];
            b    = order[$urandom_range(span - 1, pick + 1)];
         end
         send_item(CMD_ADD_EDGE, a, b);
      end
      send_item(CMD_START, $urandom_range(NODE_LIMIT - 1), $urandom_range(NODE_LIMIT - 1));
   endtask

   // One random phase: a node count, an idle mode and a run of small graphs.
   task automatic run_phase(input int unsigned count_value, input int unsigned s_pct,
                            input int unsigned r_pct, input bit long_hold);
      int unsigned span;
      int unsigned stop_at;
      set_node_count(count_value);
      sender_pct   = s_pct;
      receiver_pct <= r_pct;
      span = (count_value > NODE_LIMIT) ? NODE_LIMIT : count_value;
      if (span == 0) span = 8;
      if (long_hold) hold_asks <= hold_asks + 1;
      stop_at = items_offered + PHASE_ITEMS;
      while (items_offered < stop_at)
         send_graph(span, $urandom_range((span < 3) ? 3 : 6), $urandom_range(SHAPE_DUP));
   endtask

   initial begin
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, at the reset node count of 64 first. An empty graph emits every
      // node in index order.
      send_item(CMD_START, NODE_LIMIT - 1, NODE_LIMIT - 1);
      // The highest node gates the lowest, so node 0 comes out last.
      send_item(CMD_ADD_EDGE, NODE_LIMIT - 1, 0);
      send_item(CMD_START, 0, 0);
      // A two-node cycle leaves those nodes out and flags the run incomplete.
      send_item(CMD_ADD_EDGE, 1, 2);
      send_item(CMD_ADD_EDGE, 2, 1);
      send_item(CMD_START, 0, 0);
      // A duplicated edge counts twice and is released twice.
      send_item(CMD_ADD_EDGE, 5, 6);
      send_item(CMD_ADD_EDGE, 5, 6);
      send_item(CMD_START, 0, 0);
      // A one-node graph whose node loops onto itself: nothing is ready at the start.
      set_node_count(1);
      send_item(CMD_ADD_EDGE, 0, 0);
      send_item(CMD_START, 0, 0);
      // Edges through a node outside the graph: that node never fires, so node 1 waits.
      set_node_count(4);
      send_item(CMD_ADD_EDGE, 2, 10);
      send_item(CMD_ADD_EDGE, 10, 1);
      send_item(CMD_START, 0, 0);
      // An empty graph gives the single empty result without the incomplete flag.
      set_node_count(0);
      send_item(CMD_START, 0, 0);
      send_item(CMD_ADD_EDGE, 0, 1);
      send_item(CMD_START, 0, 0);
      // A count above the index range is limited to 64 nodes.
      set_node_count(2 ** COUNT_REG_W - 1);
      send_item(CMD_START, 0, 0);

      // Full edge store: the last few edges are dropped, and all 64 nodes sort with a
      // full scan each, which is the slowest run the unit has.
      set_node_count(NODE_LIMIT);
      send_graph(NODE_LIMIT, 260, SHAPE_DAG);

      // Random phases across node counts and idle modes; the 16-node phase carries the
      // long receiver hold-off that backs up the request channel.
      run_phase(1, 66, 0, 1'b0);
      run_phase(8, 0, 66, 1'b0);
      run_phase(2 ** COUNT_REG_W - 1, 6, 6, 1'b0);
      run_phase(16, 0, 0, 1'b1);
      run_phase(5, 66, 0, 1'b0);
      run_phase(37, 0, 66, 1'b0);
      run_phase(3, 6, 6, 1'b0);

      wait_idle();
      $display("Run covered %0d request transactions, %0d sorts and %0d results",
               items_offered, sb.sorts_run, sb.results_seen);
      $display("over %0d node count settings, with sender and receiver idling and a hold-off.",
               settings_used);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("%0d mismatches, %0d results never arrived", sb.mismatches,
                  sb.pending.size());
         $display("tb_top failed");
      end
      $finish;
   end
endmodule
